// File: rtl/core/irs_pkg.sv
package irs_pkg;

  localparam int MaxWidth    = 256;
  localparam int MaxHeight   = 256;
  localparam int MaxChannels = 4;

  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxHeight);
  localparam int ChanW  = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int AddrW  = RowW + ColW + ChanW;
  localparam int SizeW  = 9;
  localparam int CcW    = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 9;

  // numerator / divisor widths for coordinate mapping
  localparam int NumW = 34;
  localparam int DenW = 10;
  localparam int QW   = 26;

  localparam logic [CfgIdxW-1:0] RegSrcW   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSrcH   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDstW   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDstH   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegChan   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMode   = 3'd5;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpRequest = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] col;
    logic [7:0] row;
    logic [1:0] chan;
    logic [7:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] result_sample;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StMapX, StDivX, StMapY, StDivY, StRead, StWait, StMac, StDone
  } state_e;

  // divider control
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

endpackage

// File: rtl/core/irs_if.sv
interface irs_in_if;
  import irs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface irs_out_if;
  import irs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/irs_div.sv
module irs_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  irs_pkg::div_req_t        req_i,
  output logic                     done_o,
  output logic [irs_pkg::QW-1:0]   quot_o
);
  import irs_pkg::*;

  localparam int CntW = $clog2(QW + 1);

  logic [NumW-1:0] rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [QW-1:0]   numsh_q, numsh_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [NumW-1:0] trial;

  // restoring division, one quotient bit per cycle; the upper numerator bits
  // preload the remainder since the quotient fits in QW bits
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; numsh_d = numsh_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q[NumW-2:0], numsh_q[QW-1]};
    if (req_i.start) begin
      rem_d = NumW'(req_i.num >> QW); quo_d = '0; numsh_d = req_i.num[QW-1:0];
      den_d = req_i.den;
      cnt_d = CntW'(QW); busy_d = 1'b1;
    end else if (busy_q) begin
      numsh_d = {numsh_q[QW-2:0], 1'b0};
      if (trial >= NumW'(den_q)) begin
        rem_d = trial - NumW'(den_q);
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; numsh_q <= numsh_d; den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quo_d;
endmodule

// File: rtl/core/image_resample_scaler.sv
// Load item: accepted while idle, store written in the cycle after; no result.
// Request item: accepted only while idle; each axis is mapped through the shared
// bit-serial divider (skipped when the mapped coordinate is not positive), then
// the neighbours are read and weighted. No new item is accepted until the result
// register is loaded; a full result register holds the request.
// Reset (async, active low) clears control and restores defaults, not the store.
module image_resample_scaler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [irs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [irs_pkg::CfgDataW-1:0] cfg_data_i,
  irs_in_if.sink                      in_if,
  irs_out_if.source                   out_if
);
  import irs_pkg::*;

  logic [SizeW-1:0] sw_q, sh_q, tw_q, th_q;
  logic [CcW-1:0]   cc_q;
  logic             mode_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 9'd256; sh_q <= 9'd256; tw_q <= 9'd256; th_q <= 9'd256;
      cc_q <= 3'd1; mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSrcW: sw_q   <= cfg_data_i;
        RegSrcH: sh_q   <= cfg_data_i;
        RegDstW: tw_q   <= cfg_data_i;
        RegDstH: th_q   <= cfg_data_i;
        RegChan: cc_q   <= cfg_data_i[CcW-1:0];
        RegMode: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [SizeW-1:0] sws, shs, tws, ths;
  logic [CcW-1:0]   ccs;
  function automatic logic [SizeW-1:0] sat_sz(input logic [SizeW-1:0] v, input int m);
    if (v == '0) return SizeW'(1);
    if (v > SizeW'(m)) return SizeW'(m);
    return v;
  endfunction
  assign sws = sat_sz(sw_q, MaxWidth);
  assign shs = sat_sz(sh_q, MaxHeight);
  assign tws = sat_sz(tw_q, MaxWidth);
  assign ths = sat_sz(th_q, MaxHeight);
  assign ccs = (cc_q == '0) ? CcW'(1) : (cc_q > CcW'(MaxChannels)) ? CcW'(MaxChannels) : cc_q;

  // source store
  logic [7:0]       store [2**AddrW];
  logic             st_we;
  logic [AddrW-1:0] st_waddr, st_raddr;
  logic [7:0]       st_wdata, st_rdata_q;
  always_ff @(posedge clk_i) begin
    if (st_we) store[st_waddr] <= st_wdata;
    st_rdata_q <= store[st_raddr];
  end

  state_e state_q, state_d;
  in_item_t req_q;
  logic [SizeW-1:0] dx_q, dy_q;
  logic [ChanW-1:0] c_q;
  logic [QW-1:0] sx_q, sy_q;
  logic [1:0] nb_q, nb_d;
  logic [39:0] acc_q;
  logic [7:0] res_q;
  logic out_v_q;
  logic load_pend_q;
  logic res_go;

  // shared divider
  div_req_t dreq;
  logic div_done;
  logic [QW-1:0] div_quot;
  irs_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(div_done), .quot_o(div_quot));

  // map numerator: (src*(2d+1) - dst) << 16; the coordinate is zero when not positive
  logic [SizeW-1:0] msrc, mdst, md;
  logic [19:0] mprod;
  logic        mneg;
  always_comb begin
    if (state_q == StMapX) begin
      msrc = sws; mdst = tws; md = dx_q;
    end else begin
      msrc = shs; mdst = ths; md = dy_q;
    end
    mprod = 20'(msrc) * 20'({md, 1'b1});
    mneg  = (mprod <= 20'(mdst));
  end

  // neighbour coordinates
  logic [7:0]  ix, iy;
  logic [15:0] fx, fy;
  logic [SizeW-1:0] x0, x1, y0, y1, nx, ny, sx_sel, sy_sel;
  logic [16:0] wx, wy;
  always_comb begin
    ix = sx_q[23:16]; iy = sy_q[23:16]; fx = sx_q[15:0]; fy = sy_q[15:0];
    x0 = ({1'b0, ix} < sws - 1'b1) ? {1'b0, ix} : sws - 1'b1;
    x1 = ({1'b0, ix} + 1'b1 < sws - 1'b1) ? {1'b0, ix} + 1'b1 : sws - 1'b1;
    y0 = ({1'b0, iy} < shs - 1'b1) ? {1'b0, iy} : shs - 1'b1;
    y1 = ({1'b0, iy} + 1'b1 < shs - 1'b1) ? {1'b0, iy} + 1'b1 : shs - 1'b1;
    nx = fx[15] ? x1 : x0;
    ny = fy[15] ? y1 : y0;
    if (!mode_q) begin
      sx_sel = nx; sy_sel = ny;
    end else begin
      sx_sel = nb_q[0] ? x1 : x0;
      sy_sel = nb_q[1] ? y1 : y0;
    end
    wx = nb_q[0] ? {1'b0, fx} : 17'h10000 - {1'b0, fx};
    wy = nb_q[1] ? {1'b0, fy} : 17'h10000 - {1'b0, fy};
  end

  // weight product registered before the sample multiply
  logic [33:0] wprod_q;
  logic [41:0] term;
  assign term = 42'(st_rdata_q) * 42'(wprod_q);

  logic [ChanW-1:0] cs;
  assign cs = (req_q.chan < ChanW'(ccs - 1'b1)) ? req_q.chan[ChanW-1:0] : ChanW'(ccs - 1'b1);

  logic [40:0] rnd;
  assign rnd = {1'b0, acc_q} + 41'(33'h80000000);

  // finish a request once the result register is free or being emptied
  assign res_go = (state_q == StDone) && (!out_v_q || out_if.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    nb_d = nb_q;
    dreq.start = 1'b0;
    dreq.num = NumW'({20'(mprod - 20'(mdst)), 16'h0});
    dreq.den = {mdst, 1'b0};
    in_if.ready = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_if.ready = 1'b1;
        if (in_if.valid && in_if.data.op == OpRequest) begin
          nb_d = '0; state_d = StMapX;
        end
      end
      StMapX: begin
        dreq.start = !mneg; state_d = mneg ? StMapY : StDivX;
      end
      StDivX: if (div_done) state_d = StMapY;
      StMapY: begin
        dreq.start = !mneg; state_d = mneg ? StRead : StDivY;
      end
      StDivY: if (div_done) state_d = StRead;
      StRead: state_d = StWait;
      StWait: state_d = StMac;
      StMac: begin
        if (!mode_q || nb_q == 2'd3) state_d = StDone;
        else begin
          nb_d = nb_q + 1'b1; state_d = StRead;
        end
      end
      StDone: if (res_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign st_raddr = {sy_sel[RowW-1:0], sx_sel[ColW-1:0], c_q};
  assign st_we    = load_pend_q;
  assign st_waddr = {req_q.row, req_q.col, req_q.chan[ChanW-1:0]};
  assign st_wdata = req_q.sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; out_v_q <= 1'b0; load_pend_q <= 1'b0; nb_q <= '0;
    end else begin
      state_q <= state_d;
      nb_q <= nb_d;
      load_pend_q <= in_if.valid && in_if.ready && (in_if.data.op == OpLoad);
      out_v_q <= res_go || (out_v_q && !out_if.ready);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      req_q <= in_if.data;
      dx_q <= ({1'b0, in_if.data.col} < tws - 1'b1) ? {1'b0, in_if.data.col} : tws - 1'b1;
      dy_q <= ({1'b0, in_if.data.row} < ths - 1'b1) ? {1'b0, in_if.data.row} : ths - 1'b1;
      acc_q <= '0;
    end
    if (state_q == StMapX) begin
      c_q <= cs;
      if (mneg) sx_q <= '0;
    end
    if (state_q == StDivX && div_done) sx_q <= div_quot;
    if (state_q == StMapY && mneg) sy_q <= '0;
    if (state_q == StDivY && div_done) sy_q <= div_quot;
    if (state_q == StRead) wprod_q <= 34'(wx) * 34'(wy);
    if (state_q == StMac) acc_q <= acc_q + 40'(term);
    if (res_go) begin
      if (!mode_q) res_q <= st_rdata_q;
      else res_q <= (rnd[40:32] > 9'd255) ? 8'd255 : rnd[39:32];
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.data.result_sample = res_q;
endmodule
